// ===== rtl/core/dfsm_pkg.sv =====
// Shared types and constants for the diacritic-folding substring matcher.
`default_nettype none
package dfsm_pkg;

   localparam int STORED_BYTES        = 16;
   localparam int PATTERN_MAX_DEFAULT = 16;
   localparam int LEN_REG_W           = 5;

   localparam logic [7:0] LEAD_BYTE       = 8'hC3;
   localparam logic [7:0] SMALL_O_TRAIL   = 8'hB6;
   localparam logic [7:0] CAPITAL_O_TRAIL = 8'h96;
   localparam logic [7:0] SMALL_O         = 8'h6F;
   localparam logic [7:0] CAPITAL_O       = 8'h4F;

   typedef enum logic [1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_PATTERN_LEN  = 2'd2,
      CSR_EXACT_MODE   = 2'd3
   } csr_index_type;

   typedef logic [STORED_BYTES-1:0][7:0] pattern_type;

   typedef struct packed {
      logic [7:0] value_byte;
      logic       string_end;
      logic       empty_string;
   } req_item_type;

   typedef struct packed {
      logic [LEN_REG_W-1:0] active_len;
      logic                 exact;
   } match_cfg_type;

endpackage
`default_nettype wire

// ===== rtl/core/dfsm_in_stage.sv =====
// Input register stage for request bytes.
`default_nettype none
module dfsm_in_stage
   import dfsm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_ready,
   input  wire req_item_type req_item,
   input  wire logic         advance,
   output      logic         item_valid,
   output      req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   assign req_ready  = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/dfsm_match_core.sv =====
// Bit-parallel shift-and match state with o/O diacritic folding.
`default_nettype none
module dfsm_match_core
   import dfsm_pkg::*;
#(
   parameter int LANES = STORED_BYTES
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire req_item_type  item,
   input  wire pattern_type   pattern,
   input  wire match_cfg_type cfg,
   output      logic          has_result,
   output      logic          matched
);

   localparam int LEN_W = $clog2(LANES + 1);

   logic [LANES:0]   prefix_ff, prefix_in, next_p;
   logic [LANES-1:0] wait_s_ff, wait_s_in, next_s;
   logic [LANES-1:0] wait_c_ff, wait_c_in, next_c;
   logic             found_ff, found_in, found_next;
   logic             start_ff, start_in;
   logic [LANES-1:0] act_vec;
   logic [LEN_W-1:0] len_idx;
   logic             len_zero;
   logic             lane_on;
   logic [7:0]       b;
   logic [7:0]       p;

   assign b          = item.value_byte;
   assign len_idx    = cfg.active_len[LEN_W-1:0];
   assign len_zero   = (cfg.active_len == '0);
   assign has_result = item.string_end || item.empty_string;

   always_comb begin
      act_vec    = prefix_ff[LANES-1:0];
      act_vec[0] = act_vec[0] | (!cfg.exact || start_ff);
      next_p     = '0;
      next_s     = '0;
      next_c     = '0;
      lane_on    = 1'b0;
      p          = '0;
      for (int i = 0; i < LANES; i++) begin
         lane_on = (LEN_REG_W'(i) < cfg.active_len);
         p       = pattern[i];
         if (lane_on) begin
            if (act_vec[i]) begin
               if (p == b) begin
                  next_p[i+1] = 1'b1;
               end else if (b == LEAD_BYTE) begin
                  next_s[i] = (p == SMALL_O);
                  next_c[i] = (p == CAPITAL_O);
               end
            end
            if (wait_s_ff[i] && b == SMALL_O_TRAIL && p == SMALL_O) begin
               next_p[i+1] = 1'b1;
            end
            if (wait_c_ff[i] && b == CAPITAL_O_TRAIL && p == CAPITAL_O) begin
               next_p[i+1] = 1'b1;
            end
         end
      end
      found_next = found_ff || (!cfg.exact && !len_zero && next_p[len_idx]);
   end

   always_comb begin
      if (item.empty_string) begin
         matched = len_zero;
      end else if (cfg.exact) begin
         matched = next_p[len_idx];
      end else begin
         matched = found_next || len_zero;
      end
   end

   always_comb begin
      prefix_in = prefix_ff;
      wait_s_in = wait_s_ff;
      wait_c_in = wait_c_ff;
      found_in  = found_ff;
      start_in  = start_ff;
      if (step) begin
         if (has_result) begin
            prefix_in = '0;
            wait_s_in = '0;
            wait_c_in = '0;
            found_in  = 1'b0;
            start_in  = 1'b1;
         end else begin
            prefix_in = next_p;
            wait_s_in = next_s;
            wait_c_in = next_c;
            found_in  = found_next;
            start_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '0;
         wait_s_ff <= '0;
         wait_c_ff <= '0;
         found_ff  <= 1'b0;
         start_ff  <= 1'b1;
      end else begin
         prefix_ff <= prefix_in;
         wait_s_ff <= wait_s_in;
         wait_c_ff <= wait_c_in;
         found_ff  <= found_in;
         start_ff  <= start_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/diacritic_folding_substring_matcher_unit.sv =====
// Top level of the diacritic-folding substring matcher.
// Takes one value byte per cycle, unless an answer is held up in the input register, and
// answers on the last byte of each value, or on an empty-value request. A request passes
// an input register and the shift-and update, and its answer is captured in the result
// register when the request leaves the input register. A request that brings an answer
// waits in the input register only while the result register is still held by an earlier
// answer; bytes inside a value never wait. The pattern 'o' also matches the pair C3 B6 and
// 'O' the pair C3 96. Write the csr_ registers only while no request is in flight.
`default_nettype none
module diacritic_folding_substring_matcher_unit
   import dfsm_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] value_byte
   input  wire logic        req_tlast,   // string_end
   input  wire logic        req_tuser,   // [0] empty_string
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,   // [0] matched, [7:1] zero
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [63:0] csr_wdata
);

   localparam int LANES = (PATTERN_MAX < STORED_BYTES) ? PATTERN_MAX : STORED_BYTES;

   logic [63:0]          pat_low_ff, pat_high_ff;
   logic [LEN_REG_W-1:0] pat_len_ff;
   logic                 exact_ff;
   pattern_type          pattern;
   match_cfg_type        cfg;

   req_item_type req_item, item;
   logic         item_valid, advance, has_result, matched, step;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_matched_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
         exact_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_wdata;
            CSR_PATTERN_LEN:  pat_len_ff  <= csr_wdata[LEN_REG_W-1:0];
            CSR_EXACT_MODE:   exact_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign pattern    = {pat_high_ff, pat_low_ff};
   assign cfg.exact  = exact_ff;
   assign cfg.active_len = (pat_len_ff > LEN_REG_W'(LANES)) ? LEN_REG_W'(LANES) : pat_len_ff;

   assign req_item.value_byte   = req_tdata;
   assign req_item.string_end   = req_tlast;
   assign req_item.empty_string = req_tuser;

   dfsm_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   assign advance = item_valid && (!has_result || !rsp_valid_ff || rsp_tready);
   assign step    = advance;

   dfsm_match_core #(
      .LANES (LANES)
   ) u_match_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (item),
      .pattern    (pattern),
      .cfg        (cfg),
      .has_result (has_result),
      .matched    (matched)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_matched_ff <= matched;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_matched_ff};

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the diacritic-folding substring matcher unit.
`timescale 1ns / 1ps
module testbench
   import dfsm_pkg::*;
();

   localparam int IDLE_LIMIT = 2000;

   class match_scoreboard;
      logic [63:0] pat_lo;
      logic [63:0] pat_hi;
      logic [4:0]  pat_len;
      logic        exact;
      logic [16:0] prefixes;
      logic [15:0] wait_small;
      logic [15:0] wait_capital;
      logic        found;
      logic        at_start;
      logic        expected_matches[$];
      int          errors;

      function new();
         pat_lo  = '0;
         pat_hi  = '0;
         pat_len = '0;
         exact   = 1'b0;
         errors  = 0;
         restart_value();
      endfunction

      function void restart_value();
         prefixes     = '0;
         wait_small   = '0;
         wait_capital = '0;
         found        = 1'b0;
         at_start     = 1'b1;
      endfunction

      function int active_length();
         int n;
         n = int'(pat_len);
         if (n > PATTERN_MAX_DEFAULT) n = PATTERN_MAX_DEFAULT;
         if (n > STORED_BYTES) n = STORED_BYTES;
         return n;
      endfunction

      function logic [7:0] pattern_byte(int i);
         if (i < 8) return pat_lo[8*i +: 8];
         return pat_hi[8*(i-8) +: 8];
      endfunction

      function void set_register(csr_index_type idx, logic [63:0] v);
         case (idx)
            CSR_PATTERN_LOW:  pat_lo = v;
            CSR_PATTERN_HIGH: pat_hi = v;
            CSR_PATTERN_LEN:  pat_len = v[4:0];
            CSR_EXACT_MODE:   exact = v[0];
            default: ;
         endcase
      endfunction

      function void note_request(req_item_type it);
         int          n;
         logic [16:0] live;
         logic [16:0] nxt_prefix;
         logic [15:0] nxt_small;
         logic [15:0] nxt_cap;
         logic [7:0]  p;
         n = active_length();
         if (it.empty_string) begin
            expected_matches.push_back(n == 0);
            restart_value();
            return;
         end
         live = prefixes;
         if (!exact || at_start) live[0] = 1'b1;
         nxt_prefix = '0;
         nxt_small  = '0;
         nxt_cap    = '0;
         for (int i = 0; i < n; i++) begin
            p = pattern_byte(i);
            if (live[i]) begin
               if (p == it.value_byte) begin
                  nxt_prefix[i+1] = 1'b1;
               end else if (it.value_byte == LEAD_BYTE) begin
                  if (p == SMALL_O) nxt_small[i] = 1'b1;
                  if (p == CAPITAL_O) nxt_cap[i] = 1'b1;
               end
            end
            if (wait_small[i] && it.value_byte == SMALL_O_TRAIL && p == SMALL_O)
               nxt_prefix[i+1] = 1'b1;
            if (wait_capital[i] && it.value_byte == CAPITAL_O_TRAIL && p == CAPITAL_O)
               nxt_prefix[i+1] = 1'b1;
         end
         prefixes     = nxt_prefix;
         wait_small   = nxt_small;
         wait_capital = nxt_cap;
         at_start     = 1'b0;
         if (!exact && n > 0 && prefixes[n]) found = 1'b1;
         if (it.string_end) begin
            if (exact) expected_matches.push_back(prefixes[n]);
            else expected_matches.push_back(found || n == 0);
            restart_value();
         end
      endfunction

      function void check_response(logic matched);
         logic want;
         if (expected_matches.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual matched=%0b",
                     $time, matched);
            errors++;
            return;
         end
         want = expected_matches.pop_front();
         if (matched !== want) begin
            $display("%0t: matched mismatch, expected %0b, actual %0b", $time, want, matched);
            errors++;
         end
      endfunction

      function int pending();
         return expected_matches.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [63:0] csr_wdata;

   match_scoreboard sb;
   logic [7:0]      value_q[$];
   int              requests_sent;
   int              burst_left;
   int              idle_cycles;
   int              rx_cycle;
   int              rx_mode;

   diacritic_folding_substring_matcher_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      rx_cycle   = 0;
      rx_mode    = 0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (rx_cycle % 50 == 0) rx_mode = $urandom_range(0, 3);
         case (rx_mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = 1'($urandom_range(0, 1));
            2: rsp_tready = (rx_cycle % 4 == 0);
            default: rsp_tready = ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata[0]);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("testbench: FAIL");
         $finish;
      end
   end

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 7))
         0: return SMALL_O;
         1: return CAPITAL_O;
         2: return LEAD_BYTE;
         3: return SMALL_O_TRAIL;
         4: return CAPITAL_O_TRAIL;
         5: return 8'h61;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [63:0] pattern_word();
      logic [63:0] w;
      case ($urandom_range(0, 7))
         0: w = '1;
         1: w = '0;
         2: w = {$urandom, $urandom};
         default: begin
            for (int i = 0; i < 8; i++) begin
               case ($urandom_range(0, 5))
                  0: w[8*i +: 8] = SMALL_O;
                  1: w[8*i +: 8] = CAPITAL_O;
                  2: w[8*i +: 8] = 8'h61;
                  3: w[8*i +: 8] = 8'h62;
                  4: w[8*i +: 8] = LEAD_BYTE;
                  default: w[8*i +: 8] = 8'($urandom_range(0, 255));
               endcase
            end
         end
      endcase
      return w;
   endfunction

   task automatic send_req(input logic [7:0] b, input logic last, input logic empty);
      int           gap;
      req_item_type it;
      it.value_byte   = b;
      it.string_end   = last;
      it.empty_string = empty;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tlast  = last;
      req_tuser  = empty;
      do @(posedge clock); while (!req_tready);
      sb.note_request(it);
      burst_left--;
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_value();
      if (value_q.size() == 0) begin
         send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end else begin
         for (int i = 0; i < value_q.size(); i++)
            send_req(value_q[i], i == value_q.size() - 1, 1'b0);
      end
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [63:0] v);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      sb.set_register(idx, v);
   endtask

   task automatic random_config(input int phase);
      logic [4:0] len;
      if (phase == 0 || $urandom_range(0, 3) != 0) write_csr(CSR_PATTERN_LOW, pattern_word());
      if (phase == 0 || $urandom_range(0, 3) != 0) write_csr(CSR_PATTERN_HIGH, pattern_word());
      case ($urandom_range(0, 9))
         0: len = 5'd0;
         1: len = 5'd16;
         2: len = 5'($urandom_range(17, 31));
         default: len = 5'($urandom_range(1, 6));
      endcase
      if (phase == 0) len = 5'd31;
      if (phase == 1) len = 5'd16;
      write_csr(CSR_PATTERN_LEN, {59'd0, len});
      write_csr(CSR_EXACT_MODE, {63'd0, (phase == 0) ? 1'b1 : 1'($urandom_range(0, 1))});
   endtask

   task automatic build_value();
      int         kind;
      int         n;
      int         pos;
      logic [7:0] p;
      value_q.delete();
      n    = sb.active_length();
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
         if (!sb.exact) repeat ($urandom_range(0, 3)) value_q.push_back(noise_byte());
         for (int i = 0; i < n; i++) begin
            p = sb.pattern_byte(i);
            if (p == SMALL_O && $urandom_range(0, 1)) begin
               value_q.push_back(LEAD_BYTE);
               value_q.push_back(SMALL_O_TRAIL);
            end else if (p == CAPITAL_O && $urandom_range(0, 1)) begin
               value_q.push_back(LEAD_BYTE);
               value_q.push_back(CAPITAL_O_TRAIL);
            end else begin
               value_q.push_back(p);
            end
         end
         if (!sb.exact) repeat ($urandom_range(0, 3)) value_q.push_back(noise_byte());
         if ($urandom_range(0, 3) == 0 && value_q.size() > 0) begin
            pos = $urandom_range(0, value_q.size() - 1);
            case ($urandom_range(0, 2))
               0: value_q.delete(pos);
               1: value_q[pos] = noise_byte();
               default: value_q.insert(pos, LEAD_BYTE);
            endcase
         end
      end else if (kind < 9) begin
         repeat ($urandom_range(1, 12)) value_q.push_back(noise_byte());
      end
   endtask

   initial begin
      int phase;
      int target;
      sb            = new();
      requests_sent = 0;
      burst_left    = 0;
      idle_cycles   = 0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      req_tuser     = 1'b0;
      csr_we        = 1'b0;
      csr_addr      = CSR_PATTERN_LOW;
      csr_wdata     = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // empty pattern in contains mode
      value_q = {};
      send_value();
      value_q = {8'h00};
      send_value();

      wait_idle();
      write_csr(CSR_PATTERN_LOW, 64'h0000_0000_006F_4F61);
      write_csr(CSR_PATTERN_LEN, 64'd3);
      write_csr(CSR_EXACT_MODE, 64'd0);
      value_q = {8'h61, LEAD_BYTE, CAPITAL_O_TRAIL, LEAD_BYTE, SMALL_O_TRAIL};
      send_value();
      value_q = {8'h61, CAPITAL_O, SMALL_O};
      send_value();
      value_q = {8'h61, LEAD_BYTE, 8'h78};
      send_value();
      value_q = {8'h61, LEAD_BYTE};
      send_value();
      value_q = {};
      send_value();

      wait_idle();
      write_csr(CSR_EXACT_MODE, 64'd1);
      value_q = {8'h61, CAPITAL_O, SMALL_O, SMALL_O};
      send_value();

      wait_idle();
      write_csr(CSR_PATTERN_LEN, 64'd0);
      value_q = {8'hFF};
      send_value();
      value_q = {};
      send_value();

      phase = 0;
      while (requests_sent < 720) begin
         wait_idle();
         random_config(phase);
         phase++;
         target = requests_sent + $urandom_range(20, 80);
         while (requests_sent < target) begin
            build_value();
            send_value();
         end
         // leave a value open across the next register write
         if ($urandom_range(0, 3) == 0) begin
            build_value();
            foreach (value_q[i]) send_req(value_q[i], 1'b0, 1'b0);
         end
      end

      wait_idle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
